>>> design/rx_packet_deframer_crc16_defines.svh
// Assertion macros used by the deframer top-level design file.
`ifndef RX_PACKET_DEFRAMER_CRC16_DEFINES_SVH
`define RX_PACKET_DEFRAMER_CRC16_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock, off during reset.
`define RPD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpd assertion failed");
// Next-cycle implication, sampled on the rising clock, off during reset.
`define RPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpd assertion failed");
`else
`define RPD_ASSERT_IMPL(label, ante, cons)
`define RPD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> design/rpd_pkg.sv
package rpd_pkg;

    localparam int DEFAULT_MAX_PAYLOAD = 64;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int POS_W  = 6;
    localparam int CRC_W  = 16;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_TOP  = 16'h8000;

    localparam logic [BYTE_W-1:0] START_BYTE_RESET   = 8'd126;
    localparam logic [LEN_W-1:0]  LENGTH_LIMIT_RESET = 7'd64;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_LIMIT = 1'b1;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [BYTE_W-1:0]    data;
    } cfg_wr_t;

    // One finished packet handed from the parser to the result side.
    typedef struct packed {
        logic              status;
        logic [BYTE_W-1:0] id;
        logic [LEN_W-1:0]  length;
        logic [CRC_W-1:0]  rcv;
    } job_t;

    typedef struct packed {
        logic              en;
        logic [POS_W-1:0]  addr;
        logic [BYTE_W-1:0] data;
    } mem_wr_t;

    // CRC-16/CCITT-FALSE over one byte, MSB first.
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < BYTE_W; k++) begin
            if ((c & CRC_TOP) != '0)
            begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> design/rpd_front.sv
module rpd_front #(
    parameter int MAX_PAYLOAD = rpd_pkg::DEFAULT_MAX_PAYLOAD
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [7:0]       rx_byte,
    input  logic             restart,
    output logic             full,
    input  rpd_pkg::cfg_wr_t cfg,
    input  logic             job_full,
    input  logic             store_busy,
    output logic             job_push,
    output rpd_pkg::job_t    job,
    output rpd_pkg::mem_wr_t mem_wr
);
    import rpd_pkg::*;

    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_ID   = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_CRCL = 3'd4;
    localparam logic [2:0] PH_CRCH = 3'd5;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

    logic [2:0]        phase_reg, phase_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0] id_reg, id_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [BYTE_W-1:0] crc_low_reg, crc_low_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [BYTE_W-1:0] start_byte_reg;
    logic [LEN_W-1:0]  length_limit_reg;

    logic              accept;
    logic [LEN_W-1:0]  lim;
    logic [CRC_W-1:0]  crc_in;
    logic [CRC_W-1:0]  crc_out;
    logic [CRC_W-1:0]  rcv;
    logic [LEN_W-1:0]  fill_inc;

    // Hold data bytes while the store is still being drained, and the high CRC byte while the job queue is full.
    assign full   = ((phase_reg == PH_DATA) && store_busy) || ((phase_reg == PH_CRCH) && job_full);
    assign accept = push && !full;

    assign lim      = (length_limit_reg > MAX_LEN) ? MAX_LEN : length_limit_reg;
    assign crc_in   = (phase_reg == PH_LEN) ? CRC_INIT : crc_reg;
    assign crc_out  = crc16_byte(crc_in, rx_byte);
    assign rcv      = {rx_byte, crc_low_reg};
    assign fill_inc = fill_reg + LEN_W'(1);

    assign job.status = (crc_reg != rcv);
    assign job.id     = id_reg;
    assign job.length = len_reg;
    assign job.rcv    = rcv;

    always_comb
    begin
        phase_next   = phase_reg;
        len_next     = len_reg;
        id_next      = id_reg;
        fill_next    = fill_reg;
        crc_low_next = crc_low_reg;
        crc_next     = crc_reg;
        job_push     = 1'b0;
        mem_wr.en    = 1'b0;
        mem_wr.addr  = fill_reg[POS_W-1:0];
        mem_wr.data  = rx_byte;
        if (accept)
        begin
            if (restart)
            begin
                phase_next   = PH_HUNT;
                fill_next    = '0;
                crc_low_next = '0;
                crc_next     = CRC_INIT;
            end
            else
            begin
                case (phase_reg)
                    PH_HUNT:
                    begin
                        if (rx_byte == start_byte_reg)
                        begin
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN:
                    begin
                        if (rx_byte <= {1'b0, lim})
                        begin
                            len_next   = rx_byte[LEN_W-1:0];
                            crc_next   = crc_out;
                            phase_next = PH_ID;
                        end
                        else
                        begin
                            phase_next = PH_HUNT;
                        end
                    end
                    PH_ID:
                    begin
                        id_next    = rx_byte;
                        crc_next   = crc_out;
                        fill_next  = '0;
                        phase_next = (len_reg == '0) ? PH_CRCL : PH_DATA;
                    end
                    PH_DATA:
                    begin
                        mem_wr.en = (fill_reg < MAX_LEN);
                        crc_next  = crc_out;
                        fill_next = fill_inc;
                        if (fill_inc >= len_reg)
                        begin
                            phase_next = PH_CRCL;
                        end
                    end
                    PH_CRCL:
                    begin
                        crc_low_next = rx_byte;
                        phase_next   = PH_CRCH;
                    end
                    PH_CRCH:
                    begin
                        job_push   = 1'b1;
                        phase_next = PH_HUNT;
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            len_reg          <= '0;
            id_reg           <= '0;
            fill_reg         <= '0;
            crc_low_reg      <= '0;
            crc_reg          <= CRC_INIT;
            start_byte_reg   <= START_BYTE_RESET;
            length_limit_reg <= LENGTH_LIMIT_RESET;
        end
        else
        begin
            phase_reg   <= phase_next;
            len_reg     <= len_next;
            id_reg      <= id_next;
            fill_reg    <= fill_next;
            crc_low_reg <= crc_low_next;
            crc_reg     <= crc_next;
            if (cfg.valid && (cfg.index == REG_START_BYTE))
            begin
                start_byte_reg <= cfg.data;
            end
            if (cfg.valid && (cfg.index == REG_LENGTH_LIMIT))
            begin
                length_limit_reg <= cfg.data[LEN_W-1:0];
            end
        end
    end

endmodule

>>> design/rpd_job_fifo.sv
module rpd_job_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rpd_pkg::job_t din,
    output logic          full,
    input  logic          pop,
    output rpd_pkg::job_t dout,
    output logic          empty
);
    import rpd_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

>>> design/rpd_back.sv
module rpd_back #(
    parameter int MAX_PAYLOAD = rpd_pkg::DEFAULT_MAX_PAYLOAD
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rpd_pkg::mem_wr_t mem_wr,
    input  logic             job_empty,
    input  rpd_pkg::job_t    job,
    output logic             job_pop,
    output logic             back_busy,
    input  logic             pop,
    output logic             empty,
    output logic             status,
    output logic [7:0]       packet_id,
    output logic [6:0]       packet_length,
    output logic             has_data,
    output logic [5:0]       byte_position,
    output logic [7:0]       data_byte,
    output logic [15:0]      received_check,
    output logic             last
);
    import rpd_pkg::*;

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_READ = 2'd1;
    localparam logic [1:0] B_LOAD = 2'd2;

    logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
    logic [BYTE_W-1:0] rd_data_reg;

    logic [1:0]        state_reg, state_next;
    job_t              job_reg, job_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [LEN_W-1:0]  pos_inc;
    logic              slot_free;
    logic              rd_en;

    logic              valid_reg, valid_next;
    logic              status_reg, status_next;
    logic [BYTE_W-1:0] id_reg, id_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic              has_reg, has_next;
    logic [POS_W-1:0]  position_reg, position_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic [CRC_W-1:0]  rcv_reg, rcv_next;
    logic              last_reg, last_next;

    assign slot_free = !valid_reg || pop;
    assign rd_en     = (state_reg == B_READ);
    assign pos_inc   = pos_reg + LEN_W'(1);
    assign back_busy = (state_reg != B_IDLE);

    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
        begin
            mem[mem_wr.addr[AW-1:0]] <= mem_wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[pos_reg[AW-1:0]];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        job_next      = job_reg;
        pos_next      = pos_reg;
        job_pop       = 1'b0;
        valid_next    = valid_reg && !pop;
        status_next   = status_reg;
        id_next       = id_reg;
        length_next   = length_reg;
        has_next      = has_reg;
        position_next = position_reg;
        data_next     = data_reg;
        rcv_next      = rcv_reg;
        last_next     = last_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!job_empty && slot_free)
                begin
                    job_pop = 1'b1;
                    if (job.status || (job.length == '0))
                    begin
                        // Error or empty packet: one header result.
                        valid_next    = 1'b1;
                        status_next   = job.status;
                        id_next       = job.id;
                        length_next   = job.length;
                        has_next      = 1'b0;
                        position_next = '0;
                        data_next     = '0;
                        rcv_next      = job.rcv;
                        last_next     = 1'b1;
                    end
                    else
                    begin
                        job_next   = job;
                        pos_next   = '0;
                        state_next = B_READ;
                    end
                end
            end
            B_READ:
            begin
                state_next = B_LOAD;
            end
            B_LOAD:
            begin
                if (slot_free)
                begin
                    valid_next    = 1'b1;
                    status_next   = 1'b0;
                    id_next       = job_reg.id;
                    length_next   = job_reg.length;
                    has_next      = 1'b1;
                    position_next = pos_reg[POS_W-1:0];
                    data_next     = rd_data_reg;
                    rcv_next      = job_reg.rcv;
                    last_next     = (pos_inc == job_reg.length);
                    pos_next      = pos_inc;
                    state_next    = (pos_inc == job_reg.length) ? B_IDLE : B_READ;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        status_reg   <= status_next;
        id_reg       <= id_next;
        length_reg   <= length_next;
        has_reg      <= has_next;
        position_reg <= position_next;
        data_reg     <= data_next;
        rcv_reg      <= rcv_next;
        last_reg     <= last_next;
    end

    assign empty          = !valid_reg;
    assign status         = status_reg;
    assign packet_id      = id_reg;
    assign packet_length  = length_reg;
    assign has_data       = has_reg;
    assign byte_position  = position_reg;
    assign data_byte      = data_reg;
    assign received_check = rcv_reg;
    assign last           = last_reg;

endmodule

>>> design/rx_packet_deframer_crc16.sv
// Results: a header or error result goes through the job FIFO to the output register
// once the high CRC byte is taken; a payload result also goes through a store read,
// and each read waits for the previous output load. The high CRC byte stalls while
// the job FIFO is full. Throughput: one byte per cycle; payload bytes stall while the
// store drains. Reset: rst_n async active low; clears control state and the config
// registers (start byte 126, length limit 64); the payload store is not cleared.
`include "rx_packet_deframer_crc16_defines.svh"

module rx_packet_deframer_crc16 #(
    parameter int MAX_PAYLOAD = rpd_pkg::DEFAULT_MAX_PAYLOAD
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // received byte transaction
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     rx_byte,
    input  logic                           restart,
    // result transaction
    output logic                           empty,
    input  logic                           pop,
    output logic                           status,
    output logic [7:0]                     packet_id,
    output logic [6:0]                     packet_length,
    output logic                           has_data,
    output logic [5:0]                     byte_position,
    output logic [7:0]                     data_byte,
    output logic [15:0]                    received_check,
    output logic                           last,
    // configuration write transaction
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                     cfg_data
);
    import rpd_pkg::*;

    cfg_wr_t cfg;
    job_t    job_in;
    job_t    job_out;
    mem_wr_t mem_wr;
    logic    job_push;
    logic    job_pop;
    logic    job_full;
    logic    job_empty;
    logic    back_busy;
    logic    store_busy;

    // Config registers take a write on any cycle.
    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // The store is in use from the moment a packet is queued until its last byte
    // has been read out; the parser must not overwrite it in that window.
    assign store_busy = back_busy || !job_empty;

    // Front: hunt, parse and check each byte; write the payload into the store.
    rpd_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .rx_byte   (rx_byte),
        .restart   (restart),
        .full      (full),
        .cfg       (cfg),
        .job_full  (job_full),
        .store_busy(store_busy),
        .job_push  (job_push),
        .job       (job_in),
        .mem_wr    (mem_wr)
    );

    // Queue of finished packets between the parser and the result side.
    rpd_job_fifo u_job_fifo (
        .clk  (clk),
        .rst_n(rst_n),
        .push (job_push),
        .din  (job_in),
        .full (job_full),
        .pop  (job_pop),
        .dout (job_out),
        .empty(job_empty)
    );

    // Back: turn each queued packet into result transactions.
    rpd_back #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .mem_wr        (mem_wr),
        .job_empty     (job_empty),
        .job           (job_out),
        .job_pop       (job_pop),
        .back_busy     (back_busy),
        .pop           (pop),
        .empty         (empty),
        .status        (status),
        .packet_id     (packet_id),
        .packet_length (packet_length),
        .has_data      (has_data),
        .byte_position (byte_position),
        .data_byte     (data_byte),
        .received_check(received_check),
        .last          (last)
    );

    `RPD_ASSERT_IMPL(a_no_write_while_draining, mem_wr.en, !store_busy)
    `RPD_ASSERT_IMPL(a_no_push_when_full, job_push, !job_full)
    `RPD_ASSERT_NEXT(a_job_queued, job_push, !job_empty || back_busy || !empty)
    `RPD_ASSERT_IMPL(a_error_has_no_data, !empty && status, !has_data && last)
    `RPD_ASSERT_IMPL(a_last_data_position, !empty && has_data && last, ({1'b0, byte_position} + 7'd1) == packet_length)

endmodule

>>> dv/rx_packet_deframer_crc16_tb.sv
`timescale 1ns / 100ps

module rx_packet_deframer_crc16_tb;

    localparam int MAX_PAYLOAD  = rpd_pkg::DEFAULT_MAX_PAYLOAD;
    localparam int DRAIN_CYCLES = 16;      // worst result latency plus margin
    localparam int HOLD_CYCLES  = 500;     // long receiver hold-off under pressure
    localparam int CYCLE_LIMIT  = 300000;

    // Parser phases of the deframer, tracked by the predictor.
    typedef enum logic [2:0] {
        P_HUNT,
        P_LEN,
        P_ID,
        P_DATA,
        P_CRC_LO,
        P_CRC_HI
    } parse_phase_t;

    // Where a directed row takes its byte from.
    typedef enum logic [1:0] {
        SRC_LIT,         // literal value in the row
        SRC_CRC_LO,      // low byte of the running check
        SRC_CRC_HI,      // high byte of the running check
        SRC_CRC_BAD_HI   // inverted high byte, forces a mismatch
    } byte_src_t;

    // Which expectation a directed row produces.
    typedef enum logic [1:0] {
        EXP_MODEL,       // whatever the predictor works out
        EXP_NONE,        // nothing at all
        EXP_HEADER,      // one good header result, typed in the row
        EXP_ERROR        // one CRC error result, typed in the row
    } row_exp_t;

    typedef struct packed {
        byte_src_t   src;
        logic [7:0]  value;
        logic        rs;
        row_exp_t    exp;
        logic [7:0]  id;
        logic [6:0]  len;
    } stim_row_t;

    typedef struct packed {
        logic        status;
        logic [7:0]  id;
        logic [6:0]  len;
        logic        has;
        logic [5:0]  pos;
        logic [7:0]  data;
        logic [15:0] rcv;
        logic        last;
    } frame_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic push;
    logic full;
    logic [7:0] rx_byte;
    logic restart;
    logic empty;
    logic pop;
    logic status;
    logic [7:0] packet_id;
    logic [6:0] packet_length;
    logic has_data;
    logic [5:0] byte_position;
    logic [7:0] data_byte;
    logic [15:0] received_check;
    logic last;
    logic cfg_valid;
    logic cfg_ready;
    logic [rpd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [7:0] cfg_data;

    rx_packet_deframer_crc16 dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .rx_byte        (rx_byte),
        .restart        (restart),
        .empty          (empty),
        .pop            (pop),
        .status         (status),
        .packet_id      (packet_id),
        .packet_length  (packet_length),
        .has_data       (has_data),
        .byte_position  (byte_position),
        .data_byte      (data_byte),
        .received_check (received_check),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state: its own copy of the registers and the parser.
    logic [7:0]   set_start;
    logic [6:0]   set_limit;
    parse_phase_t phase;
    logic [6:0]   hold_len;
    logic [7:0]   hold_id;
    logic [6:0]   fill;
    logic [7:0]   crc_lo;
    logic [15:0]  crc_acc;
    logic [7:0]   store [MAX_PAYLOAD];

    frame_result_t pending [$];     // results still owed by the block, oldest first

    bit use_table_value = 1'b0;     // directed row types its own expectation
    bit tx_burst = 1'b0;            // sender offers back to back
    bit rx_burst = 1'b0;            // receiver pops every cycle outside a hold-off
    bit hold_request = 1'b0;        // ask the receiver for a long hold-off

    int items_sent      = 0;
    int results_total   = 0;
    int results_checked = 0;
    int frames_good     = 0;
    int frames_bad      = 0;
    int error_count     = 0;
    int cycle_count     = 0;

    // Directed bytes. Rows after reset use start byte 126 and limit 64.
    stim_row_t script [0:29] = '{
        '{SRC_LIT,        8'h00, 1'b0, EXP_MODEL,  8'h00, 7'd0},  // noise while hunting
        '{SRC_LIT,        8'h7E, 1'b0, EXP_MODEL,  8'h00, 7'd0},  // start byte
        '{SRC_LIT,        8'h00, 1'b0, EXP_MODEL,  8'h00, 7'd0},  // empty payload
        '{SRC_LIT,        8'hFF, 1'b0, EXP_MODEL,  8'h00, 7'd0},
        '{SRC_CRC_LO,     8'h00, 1'b0, EXP_MODEL,  8'h00, 7'd0},
        '{SRC_CRC_HI,     8'h00, 1'b0, EXP_HEADER, 8'hFF, 7'd0},
        '{SRC_LIT,        8'h7E, 1'b0, EXP_MODEL,  8'h00, 7'd0},
        '{SRC_LIT,        8'h01, 1'b0, EXP_MODEL,  8'h00, 7'd0},
        '{SRC_LIT,        8'h00, 1'b0, EXP_MODEL,  8'h00, 7'd0},
        '{SRC_LIT,        8'hFF, 1'b0, EXP_MODEL,  8'h00, 7'd0},
        '{SRC_CRC_LO,     8'h00, 1'b0, EXP_MODEL,  8'h00, 7'd0},
        '{SRC_CRC_BAD_HI, 8'h00, 1'b0, EXP_ERROR,  8'h00, 7'd1},  // CRC mismatch
        '{SRC_LIT,        8'h7E, 1'b0, EXP_MODEL,  8'h00, 7'd0},
        '{SRC_LIT,        8'h7E, 1'b0, EXP_MODEL,  8'h00, 7'd0},  // length over limit
        '{SRC_LIT,        8'h00, 1'b0, EXP_MODEL,  8'h00, 7'd0},  // would open a frame
        '{SRC_LIT,        8'h5A, 1'b0, EXP_MODEL,  8'h00, 7'd0},  //   if the rejected
        '{SRC_LIT,        8'h12, 1'b0, EXP_MODEL,  8'h00, 7'd0},  //   length counted as
        '{SRC_LIT,        8'h34, 1'b0, EXP_NONE,   8'h00, 7'd0},  //   a start byte
        '{SRC_LIT,        8'h7E, 1'b0, EXP_MODEL,  8'h00, 7'd0},
        '{SRC_LIT,        8'h02, 1'b0, EXP_MODEL,  8'h00, 7'd0},
        '{SRC_LIT,        8'h3C, 1'b0, EXP_MODEL,  8'h00, 7'd0},
        '{SRC_LIT,        8'hA5, 1'b0, EXP_MODEL,  8'h00, 7'd0},
        '{SRC_LIT,        8'h7E, 1'b1, EXP_NONE,   8'h00, 7'd0},  // restart mid payload
        '{SRC_LIT,        8'h7E, 1'b0, EXP_MODEL,  8'h00, 7'd0},
        '{SRC_LIT,        8'h02, 1'b0, EXP_MODEL,  8'h00, 7'd0},
        '{SRC_LIT,        8'hC3, 1'b0, EXP_MODEL,  8'h00, 7'd0},
        '{SRC_LIT,        8'h80, 1'b0, EXP_MODEL,  8'h00, 7'd0},
        '{SRC_LIT,        8'h01, 1'b0, EXP_MODEL,  8'h00, 7'd0},
        '{SRC_CRC_LO,     8'h00, 1'b0, EXP_MODEL,  8'h00, 7'd0},
        '{SRC_CRC_HI,     8'h00, 1'b0, EXP_MODEL,  8'h00, 7'd0}
    };

    // CRC-16/CCITT-FALSE, one data bit at a time, MSB first.
    function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0};
            if (fb)
                c = c ^ rpd_pkg::CRC_POLY;
        end
        return c;
    endfunction

    function automatic frame_result_t make_result(input logic st, input logic [7:0] id,
                                                  input logic [6:0] len, input logic has,
                                                  input logic [5:0] pos, input logic [7:0] data,
                                                  input logic [15:0] rcv, input logic lst);
        frame_result_t r;
        r.status = st;
        r.id     = id;
        r.len    = len;
        r.has    = has;
        r.pos    = pos;
        r.data   = data;
        r.rcv    = rcv;
        r.last   = lst;
        return r;
    endfunction

    function automatic void owe_result(input logic st, input logic has, input logic [5:0] pos,
                                       input logic [7:0] data, input logic [15:0] rcv,
                                       input logic lst);
        results_total++;
        if (!use_table_value)
            pending.push_back(make_result(st, hold_id, hold_len, has, pos, data, rcv, lst));
    endfunction

    function automatic int eff_limit();
        return (set_limit > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(set_limit);
    endfunction

    function automatic void reset_parser();
        set_start = rpd_pkg::START_BYTE_RESET;
        set_limit = rpd_pkg::LENGTH_LIMIT_RESET;
        phase     = P_HUNT;
        hold_len  = '0;
        hold_id   = '0;
        fill      = '0;
        crc_lo    = '0;
        crc_acc   = rpd_pkg::CRC_INIT;
    endfunction

    // Advance the parser by one accepted byte and owe the results it causes.
    function automatic void deframe_byte(input logic [7:0] b, input logic rs);
        logic [15:0] rcv;
        if (rs)
        begin
            // Drop the partial frame; length and id stay as they were.
            phase   = P_HUNT;
            fill    = '0;
            crc_lo  = '0;
            crc_acc = rpd_pkg::CRC_INIT;
            return;
        end
        case (phase)
            P_HUNT:
            begin
                if (b == set_start)
                    phase = P_LEN;
            end
            P_LEN:
            begin
                // A rejected length goes back to the hunt without a second look.
                if (b <= eff_limit())
                begin
                    hold_len = b[6:0];
                    crc_acc  = crc_next(rpd_pkg::CRC_INIT, b);
                    phase    = P_ID;
                end
                else
                    phase = P_HUNT;
            end
            P_ID:
            begin
                hold_id = b;
                crc_acc = crc_next(crc_acc, b);
                fill    = '0;
                phase   = (hold_len == 0) ? P_CRC_LO : P_DATA;
            end
            P_DATA:
            begin
                if (fill < MAX_PAYLOAD)
                    store[fill[5:0]] = b;
                crc_acc = crc_next(crc_acc, b);
                fill    = fill + 7'd1;
                if (fill >= hold_len)
                    phase = P_CRC_LO;
            end
            P_CRC_LO:
            begin
                crc_lo = b;
                phase  = P_CRC_HI;
            end
            P_CRC_HI:
            begin
                rcv   = {b, crc_lo};
                phase = P_HUNT;
                if (crc_acc != rcv)
                begin
                    frames_bad++;
                    owe_result(1'b1, 1'b0, '0, '0, rcv, 1'b1);
                end
                else
                begin
                    frames_good++;
                    if (hold_len == 0)
                        owe_result(1'b0, 1'b0, '0, '0, rcv, 1'b1);
                    for (int n = 0; n < hold_len && n < MAX_PAYLOAD; n++)
                        owe_result(1'b0, 1'b1, n[5:0], store[n[5:0]], rcv,
                                   (n + 1 == hold_len));
                end
            end
            default:
                phase = P_HUNT;
        endcase
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int pick_length(input int eff);
        if (eff == 0)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, eff);
        return $urandom_range(0, (eff < 6) ? eff : 6);
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] mismatch on result %0d: %s", $time, results_checked, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] seen,
                               input logic [15:0] want);
        if (seen !== want)
            report_mismatch($sformatf("%s is %h, expected %h", name, seen, want));
    endtask

    // Compare the result taken at this edge with the oldest one owed.
    task automatic check_result();
        frame_result_t want;
        results_checked++;
        if (pending.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result, id %h position %0d",
                                      packet_id, byte_position));
            return;
        end
        want = pending.pop_front();
        check_field("status", 16'(status), 16'(want.status));
        check_field("packet_id", 16'(packet_id), 16'(want.id));
        check_field("packet_length", 16'(packet_length), 16'(want.len));
        check_field("has_data", 16'(has_data), 16'(want.has));
        check_field("byte_position", 16'(byte_position), 16'(want.pos));
        check_field("data_byte", 16'(data_byte), 16'(want.data));
        check_field("received_check", received_check, want.rcv);
        check_field("last", 16'(last), 16'(want.last));
    endtask

    // Offer one byte, hold it until taken, then feed the predictor.
    task automatic send_byte(input logic [7:0] b, input logic rs);
        int gap;
        gap = tx_burst ? 0 : idle_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        restart <= rs;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
        deframe_byte(b, rs);
    endtask

    // Send a whole frame; flip corrupts the CRC, cut > 0 aborts with a restart there.
    task automatic send_frame(input int len, input logic [15:0] flip, input int cut);
        logic [7:0]  bytes [$];
        logic [15:0] crc;
        bytes.push_back(set_start);
        bytes.push_back(8'(len));
        bytes.push_back(rand_byte());
        repeat (len)
            bytes.push_back(rand_byte());
        crc = rpd_pkg::CRC_INIT;
        for (int k = 1; k < bytes.size(); k++)
            crc = crc_next(crc, bytes[k]);
        crc = crc ^ flip;
        bytes.push_back(crc[7:0]);
        bytes.push_back(crc[15:8]);
        for (int k = 0; k < bytes.size(); k++)
        begin
            if (cut > 0 && k == cut)
            begin
                send_byte(rand_byte(), 1'b1);
                break;
            end
            send_byte(bytes[k], 1'b0);
        end
    endtask

    // Mostly well-formed frames; the rest bad CRCs, aborts, long lengths and noise.
    task automatic send_random_frame();
        int kind;
        int len;
        int eff;
        eff = eff_limit();
        tx_burst = ($urandom_range(0, 3) == 0);
        kind = $urandom_range(0, 99);
        if (kind < 87)
        begin
            len = pick_length(eff);
            if (kind < 70)
                send_frame(len, '0, 0);
            else if (kind < 80)
                send_frame(len, 16'($urandom_range(1, 16'hFFFF)), 0);
            else
                send_frame(len, '0, $urandom_range(1, len + 4));
        end
        else if (kind < 93)
        begin
            send_byte(set_start, 1'b0);
            send_byte(8'($urandom_range(eff + 1, 255)), 1'b0);
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                send_byte(rand_byte(), 1'b0);
            if ($urandom_range(0, 1) == 1)
                send_byte(rand_byte(), 1'b1);
        end
    endtask

    task automatic run_traffic(input int min_items, input int min_results);
        int items0;
        int res0;
        items0 = items_sent;
        res0   = results_total;
        while (items_sent - items0 < min_items || results_total - res0 < min_results)
            send_random_frame();
    endtask

    // Stop offering, wait for every owed result, then let the block settle.
    task automatic wait_drained();
        push <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write both registers in one burst; valid stays high between the two transactions.
    task automatic write_settings(input logic [7:0] start_val, input logic [6:0] limit_val);
        cfg_valid <= 1'b1;
        cfg_index <= rpd_pkg::REG_START_BYTE;
        cfg_data  <= start_val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        set_start = start_val;
        cfg_index <= rpd_pkg::REG_LENGTH_LIMIT;
        cfg_data  <= {1'b0, limit_val};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        set_limit = limit_val;
        cfg_valid <= 1'b0;
    endtask

    // Receiver: pop with random stalls, burst stretches, and one long hold-off on request.
    initial
    begin : result_side
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && pop && !empty)
                check_result();
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if ($urandom_range(0, 63) == 0)
                rx_burst = !rx_burst;
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                if (!rx_burst)
                    stall_left = idle_gap();
            end
        end
    end

    // Watchdog: give up if the run hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("cycle limit hit with %0d results still owed", pending.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : stimulus
        stim_row_t  row;
        logic [7:0] b;
        logic [7:0] prev;
        rst_n     <= 1'b0;
        push      <= 1'b0;
        rx_byte   <= '0;
        restart   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= rpd_pkg::REG_START_BYTE;
        cfg_data  <= '0;
        prev = '0;
        reset_parser();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed bytes with the reset register values; the last rows go back to back.
        for (int i = 0; i < $size(script); i++)
        begin
            row = script[i];
            tx_burst = (i >= 23);
            case (row.src)
                SRC_CRC_LO:     b = crc_acc[7:0];
                SRC_CRC_HI:     b = crc_acc[15:8];
                SRC_CRC_BAD_HI: b = ~crc_acc[15:8];
                default:        b = row.value;
            endcase
            use_table_value = (row.exp != EXP_MODEL);
            send_byte(b, row.rs);
            use_table_value = 1'b0;
            if (row.exp == EXP_HEADER || row.exp == EXP_ERROR)
                pending.push_back(make_result(row.exp == EXP_ERROR, row.id, row.len, 1'b0,
                                              '0, '0, {b, prev}, 1'b1));
            prev = b;
        end
        wait_drained();

        // Zero limit: only empty frames get through; all-ones start byte.
        write_settings(8'hFF, 7'd0);
        run_traffic(12, 2);
        wait_drained();

        // Limit above the buffer with the receiver held off: a full 64-byte frame
        // backs up behind the held output while a second frame stalls in its payload,
        // then a length of 65 is rejected. All-zeros start byte.
        write_settings(8'h00, 7'd127);
        hold_request = 1'b1;
        tx_burst = 1'b1;
        send_frame(MAX_PAYLOAD, '0, 0);
        send_frame(4, '0, 0);
        send_byte(8'h00, 1'b0);
        send_byte(8'(MAX_PAYLOAD + 1), 1'b0);
        wait_drained();

        // Random traffic at a random setting.
        write_settings(rand_byte(), 7'($urandom_range(1, MAX_PAYLOAD)));
        run_traffic(30, 10);
        wait_drained();

        $display("Sent %0d bytes: %0d frames passed CRC, %0d failed, several settings.",
                 items_sent, frames_good, frames_bad);
        $display("Checked %0d results, %0d mismatches.", results_checked, error_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> rx_packet_deframer_crc16.f
+incdir+design
design/rpd_pkg.sv
design/rpd_front.sv
design/rpd_job_fifo.sv
design/rpd_back.sv
design/rx_packet_deframer_crc16.sv
dv/rx_packet_deframer_crc16_tb.sv
